/* rtl/core/rlecd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rlecd_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_FWD   = 2'd2,
      OP_BWD   = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] value;
      logic [7:0] run;
   } cmd_type;

   localparam int PairWidth    = 16;
   localparam int HeightWidth  = 5;
   localparam logic [HeightWidth-1:0] HeightReset = 5'd15;

endpackage

`default_nettype wire

/* rtl/core/rlecd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlecd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire                        clock,
   input  wire                        wr_en,
   input  wire [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire [WIDTH-1:0]            wr_data,
   input  wire                        rd_en,
   input  wire [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/rlecd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlecd_front
   import rlecd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire [1:0]   req_kind,
   input  wire [7:0]   req_value,
   input  wire [7:0]   req_run,
   output logic        cmd_valid,
   input  wire         cmd_ready,
   output cmd_type     cmd
);

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;
   cmd_type     incoming;

   always_comb begin
      incoming.op    = op_type'(req_kind);
      incoming.value = req_value;
      incoming.run   = req_run;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/rlecd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlecd_back
   import rlecd_pkg::*;
#(
   parameter int PAIR_DEPTH = 1024,
   parameter int MAX_ROWS   = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire [HeightWidth-1:0]  height,
   input  wire                    cmd_valid,
   output logic                   cmd_ready,
   input  cmd_type                cmd,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [7:0]             rsp_value,
   output logic [7:0]             rsp_column,
   output logic [3:0]             rsp_row,
   output logic                   rsp_last,
   output logic                   rsp_oor
);

   localparam int PW = $clog2(PAIR_DEPTH);
   localparam int CW = PW + 1;
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int NW = (RW > HeightWidth) ? RW : HeightWidth;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FWAIT = 2'd2;
   localparam logic [1:0] ST_BWAIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         load_count_ff, load_count_in;
   logic [CW-1:0]         cursor_ff, cursor_in;
   logic [7:0]            cur_value_ff, cur_value_in;
   logic [7:0]            rem_run_ff, rem_run_in;
   logic [7:0]            cur_run_ff, cur_run_in;
   logic [7:0]            column_ff, column_in;
   logic [NW-1:0]         tiles_left_ff, tiles_left_in;
   logic [NW-1:0]         row_ff, row_in;
   logic                  bwd_ff, bwd_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_value_ff, rsp_value_in;
   logic [7:0]            rsp_column_ff, rsp_column_in;
   logic [3:0]            rsp_row_ff, rsp_row_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic                  mem_we;
   logic                  mem_re;
   logic [PW-1:0]         mem_raddr;
   logic [PairWidth-1:0]  mem_rdata;

   logic [NW-1:0]         rows_n;
   logic                  out_free;
   logic                  tile_last;
   logic                  at_start;
   logic [CW-1:0]         cursor_inc;
   logic [CW-1:0]         cursor_dec;
   logic [7:0]            rem_dec;
   logic                  emit;
   logic [7:0]            emit_value;
   logic                  emit_oor;

   rlecd_ram #(
      .WIDTH (PairWidth),
      .DEPTH (PAIR_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (load_count_ff[PW-1:0]),
      .wr_data ({cmd.value, cmd.run}),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rows_n     = (NW'(height) > NW'(MAX_ROWS)) ? NW'(MAX_ROWS) : NW'(height);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign tile_last  = (tiles_left_ff == NW'(1));
   assign cursor_inc = cursor_ff + CW'(1);
   assign cursor_dec = cursor_ff - CW'(1);
   assign rem_dec    = rem_run_ff - 8'd1;
   assign at_start   = (cursor_ff >= load_count_ff) || (rem_run_ff == cur_run_ff);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      cursor_in     = cursor_ff;
      cur_value_in  = cur_value_ff;
      rem_run_in    = rem_run_ff;
      cur_run_in    = cur_run_ff;
      column_in     = column_ff;
      tiles_left_in = tiles_left_ff;
      row_in        = row_ff;
      bwd_in        = bwd_ff;
      cmd_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      emit          = 1'b0;
      emit_value    = 8'd0;
      emit_oor      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_LOAD: begin
                     if (load_count_ff < CW'(PAIR_DEPTH)) begin
                        mem_we        = 1'b1;
                        load_count_in = load_count_ff + CW'(1);
                        if (cursor_ff == load_count_ff) begin
                           cur_value_in = cmd.value;
                           rem_run_in   = cmd.run;
                           cur_run_in   = cmd.run;
                        end
                     end
                  end
                  OP_START: begin
                     cursor_in = '0;
                     column_in = 8'd0;
                     if (load_count_ff != '0) begin
                        mem_re        = 1'b1;
                        tiles_left_in = '0;
                        state_in      = ST_FWAIT;
                     end else begin
                        cur_value_in = 8'd0;
                        rem_run_in   = 8'd0;
                     end
                  end
                  OP_FWD, OP_BWD: begin
                     bwd_in        = (cmd.op == OP_BWD);
                     tiles_left_in = rows_n;
                     row_in        = (cmd.op == OP_BWD) ? rows_n - NW'(1) : '0;
                     if (cmd.op == OP_BWD) begin
                        column_in = column_ff - 8'd1;
                     end else if (rows_n == '0) begin
                        column_in = column_ff + 8'd1;
                     end
                     if (rows_n != '0) begin
                        state_in = ST_RUN;
                     end
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (out_free) begin
               if (!bwd_ff) begin
                  emit = 1'b1;
                  if (tile_last) begin
                     column_in = column_ff + 8'd1;
                     state_in  = ST_IDLE;
                  end
                  if (cursor_ff >= load_count_ff) begin
                     emit_oor = 1'b1;
                  end else begin
                     emit_value = cur_value_ff;
                     rem_run_in = rem_dec;
                     if (rem_dec == 8'd0) begin
                        cursor_in = cursor_inc;
                        if (cursor_inc < load_count_ff) begin
                           mem_re    = 1'b1;
                           mem_raddr = cursor_inc[PW-1:0];
                           state_in  = ST_FWAIT;
                        end else begin
                           cur_value_in = 8'd0;
                        end
                     end
                  end
               end else if (at_start && (cursor_ff == '0)) begin
                  emit     = 1'b1;
                  emit_oor = 1'b1;
                  if (tile_last) begin
                     state_in = ST_IDLE;
                  end
               end else if (at_start) begin
                  cursor_in = cursor_dec;
                  mem_re    = 1'b1;
                  mem_raddr = cursor_dec[PW-1:0];
                  state_in  = ST_BWAIT;
               end else begin
                  emit       = 1'b1;
                  emit_value = cur_value_ff;
                  rem_run_in = rem_run_ff + 8'd1;
                  if (tile_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_FWAIT: begin
            cur_value_in = mem_rdata[15:8];
            rem_run_in   = mem_rdata[7:0];
            cur_run_in   = mem_rdata[7:0];
            state_in     = (tiles_left_ff == '0) ? ST_IDLE : ST_RUN;
         end
         ST_BWAIT: begin
            if (out_free) begin
               cur_value_in = mem_rdata[15:8];
               cur_run_in   = mem_rdata[7:0];
               rem_run_in   = 8'd1;
               emit         = 1'b1;
               emit_value   = mem_rdata[15:8];
               state_in     = tile_last ? ST_IDLE : ST_RUN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         tiles_left_in = tiles_left_ff - NW'(1);
         row_in        = bwd_ff ? row_ff - NW'(1) : row_ff + NW'(1);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_column_in = rsp_column_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_oor_in    = rsp_oor_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = emit_value;
         rsp_column_in = column_ff;
         rsp_row_in    = row_ff[3:0];
         rsp_last_in   = tile_last;
         rsp_oor_in    = emit_oor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         cursor_ff     <= '0;
         cur_value_ff  <= 8'd0;
         rem_run_ff    <= 8'd0;
         cur_run_ff    <= 8'd0;
         column_ff     <= 8'd0;
         tiles_left_ff <= '0;
         row_ff        <= '0;
         bwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         cursor_ff     <= cursor_in;
         cur_value_ff  <= cur_value_in;
         rem_run_ff    <= rem_run_in;
         cur_run_ff    <= cur_run_in;
         column_ff     <= column_in;
         tiles_left_ff <= tiles_left_in;
         row_ff        <= row_in;
         bwd_ff        <= bwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_column_ff <= rsp_column_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_column = rsp_column_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_oor    = rsp_oor_ff;

`ifndef SYNTHESIS
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= load_count_ff)
      else $error("pair cursor passed the loaded pairs");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CW'(PAIR_DEPTH))
      else $error("load count exceeds the pair store depth");

   a_run_has_tiles: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> tiles_left_ff != '0)
      else $error("decode running with no tiles left");

   a_wait_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff != $past(state_ff)) && (state_ff == ST_FWAIT || state_ff == ST_BWAIT)
      |-> $past(mem_re))
      else $error("fetch wait entered without a store read");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> load_count_ff == $past(load_count_ff) + CW'(1))
      else $error("store write did not advance the load count");
`endif

endmodule

`default_nettype wire

/* rtl/core/bidirectional_rle_column_decoder_unit.sv */
// Run-length column decoder.
// The req channel carries one transaction per command: tuser selects load pair, rewind,
// decode column forward or decode column backward; tdata carries the pair for a load.
// Load and rewind transactions produce nothing on the rsp channel. A column transaction
// produces one rsp transaction per tile, the height written on the csr channel capped
// at MAX_ROWS, with tlast on the final tile of the column.
// A two-entry command queue lets req transactions be taken while the decoder works.
// A rewind reads the first pair from the pair store when any pair is loaded.
// A column emits one tile per cycle while the rsp port is free, pausing for each
// pair-store read at a run boundary; each tile is registered before the rsp port.
// The csr channel is always ready and must only be written while the block is idle.
// Reset clears the loaded pair count, the cursor and the column and sets the height
// to 15; the pair store itself is not cleared. When rsp_tready is low the current
// tile holds on the rsp port and the decoder pauses until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module bidirectional_rle_column_decoder_unit
   import rlecd_pkg::*;
#(
   parameter int PAIR_DEPTH = 1024,
   parameter int MAX_ROWS   = 16
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [15:0]             req_tdata,   // entry_value, entry_run
   input  wire [1:0]              req_tuser,   // req_type
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [23:0]            rsp_tdata,   // tile_value, column, row, zero pad
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,   // out_of_range
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [HeightWidth-1:0]  csr_data
);

   logic [HeightWidth-1:0] height_ff, height_in;
   logic                   cmd_valid;
   logic                   cmd_ready;
   cmd_type                cmd;
   logic [7:0]             tile_value;
   logic [7:0]             tile_column;
   logic [3:0]             tile_row;

   assign csr_ready = 1'b1;
   assign height_in = (csr_valid && csr_ready) ? csr_data : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= HeightReset;
      end else begin
         height_ff <= height_in;
      end
   end

   rlecd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_value (req_tdata[7:0]),
      .req_run   (req_tdata[15:8]),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   rlecd_back #(
      .PAIR_DEPTH (PAIR_DEPTH),
      .MAX_ROWS   (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .height     (height_ff),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (tile_value),
      .rsp_column (tile_column),
      .rsp_row    (tile_row),
      .rsp_last   (rsp_tlast),
      .rsp_oor    (rsp_tuser)
   );

   assign rsp_tdata = {4'd0, tile_row, tile_column, tile_value};

endmodule

`default_nettype wire
